// File: rtl/core/thp_pkg.sv
// shared types and constants of the timer handle pool
package thp_pkg;

   // action codes as they arrive on the request channel
   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_ALLOC   = 3'd1,
      ACT_FREE    = 3'd2,
      ACT_RESTART = 3'd3,
      ACT_READ    = 3'd4
   } act_type;

   // decoded operation, one-hot, handed from front to back
   typedef enum logic [5:0] {
      OP_TICK    = 6'b000001,
      OP_ALLOC   = 6'b000010,
      OP_FREE    = 6'b000100,
      OP_RESTART = 6'b001000,
      OP_READ    = 6'b010000,
      OP_NONE    = 6'b100000
   } op_type;

   // one classified command
   typedef struct packed {
      op_type     op;
      logic [2:0] handle;
      logic       handle_ok;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic        ok;
      logic [2:0]  handle_out;
      logic [15:0] elapsed;
   } rsp_type;

   // register map
   localparam logic [0:0]  REG_WRAP_LIMIT   = 1'b0;
   localparam logic [15:0] WRAP_LIMIT_RESET = 16'd30000;

   // handles reachable through the 3-bit handle field
   localparam int HANDLE_SPAN = 8;

endpackage

// File: rtl/core/timer_handle_pool_top.sv
// top level of the timer handle pool
// A pool of NUM_TIMERS software timers on one 16-bit tick counter. Each
// request transfer carries one action (tick, allocate, free, restart, read)
// and yields exactly one response transfer, in order. A request is decoded
// and placed in a two-entry command queue; while the response side does not
// stall, the back end executes one command per cycle against the timer state
// and loads the response register, so the block sustains one action per
// cycle. The combinational state update in the back end sets that rate. An
// accepted request is written into a queue slot, then executed from the queue
// head into the response register, from which it transfers. Only handles
// below NUM_TIMERS, at most 0 to 7, can be freed, restarted or read. No
// clearing pass follows reset. The wrap limit register sits at byte address
// 0 of the csr port and should be written only while no action is in flight.
module timer_handle_pool_top #(
   parameter int NUM_TIMERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic  [2:0] req_action,
   input  logic  [2:0] req_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic  [2:0] rsp_handle_out,
   output logic [15:0] rsp_elapsed,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic  [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   thp_pkg::cmd_type front_cmd;
   thp_pkg::cmd_type head_cmd;
   thp_pkg::rsp_type rsp;
   logic             q_full;
   logic             q_not_empty;
   logic             q_pop;
   logic             req_take;
   logic [15:0]      wrap_limit_ff, wrap_limit_in;
   logic             csr_write;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      wrap_limit_in = wrap_limit_ff;
      if (csr_write && csr_paddr[2] == thp_pkg::REG_WRAP_LIMIT) begin
         wrap_limit_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_limit_ff <= thp_pkg::WRAP_LIMIT_RESET;
      end else begin
         wrap_limit_ff <= wrap_limit_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == thp_pkg::REG_WRAP_LIMIT)
                       ? {16'd0, wrap_limit_ff} : 32'd0;

   // request side
   assign req_stall = q_full;
   assign req_take  = req_valid && !q_full;

   thp_front #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_front (
      .req_action (req_action),
      .req_handle (req_handle),
      .cmd        (front_cmd)
   );

   thp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   thp_back #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wrap_limit (wrap_limit_ff),
      .cmd_valid  (q_not_empty),
      .cmd        (head_cmd),
      .cmd_pop    (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // response fields
   assign rsp_ok         = rsp.ok;
   assign rsp_handle_out = rsp.handle_out;
   assign rsp_elapsed    = rsp.elapsed;

endmodule

// File: rtl/core/thp_front.sv
// front end: decodes the request and checks the handle range
module thp_front #(
   parameter int NUM_TIMERS = 8
) (
   input  logic             [2:0] req_action,
   input  logic             [2:0] req_handle,
   output thp_pkg::cmd_type       cmd
);

   localparam logic [3:0] HANDLE_LIMIT =
      4'((NUM_TIMERS > thp_pkg::HANDLE_SPAN) ? thp_pkg::HANDLE_SPAN : NUM_TIMERS);

   // classify the action into a one-hot operation
   always_comb begin
      cmd.handle    = req_handle;
      cmd.handle_ok = ({1'b0, req_handle} < HANDLE_LIMIT);
      unique case (req_action)
         thp_pkg::ACT_TICK:    cmd.op = thp_pkg::OP_TICK;
         thp_pkg::ACT_ALLOC:   cmd.op = thp_pkg::OP_ALLOC;
         thp_pkg::ACT_FREE:    cmd.op = thp_pkg::OP_FREE;
         thp_pkg::ACT_RESTART: cmd.op = thp_pkg::OP_RESTART;
         thp_pkg::ACT_READ:    cmd.op = thp_pkg::OP_READ;
         default:              cmd.op = thp_pkg::OP_NONE;
      endcase
   end

endmodule

// File: rtl/core/thp_queue.sv
// two-entry command queue between front and back
module thp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  thp_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output thp_pkg::cmd_type head_cmd
);

   thp_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/thp_back.sv
// back end: timer state, command execution and result register
module thp_back #(
   parameter int NUM_TIMERS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic      [15:0] wrap_limit,
   input  logic             cmd_valid,
   input  thp_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output thp_pkg::rsp_type rsp
);

   localparam int ADDR_DEPTH =
      (NUM_TIMERS > thp_pkg::HANDLE_SPAN) ? thp_pkg::HANDLE_SPAN : NUM_TIMERS;
   localparam int ADDR_W  = (ADDR_DEPTH > 1) ? $clog2(ADDR_DEPTH) : 1;
   localparam int GRANT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   logic [15:0]         tick_ff, tick_in;
   logic [15:0]         stamp_ff [ADDR_DEPTH];
   logic [15:0]         stamp_in [ADDR_DEPTH];
   logic [NUM_TIMERS-1:0] busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   thp_pkg::rsp_type    rsp_ff, rsp_in;

   logic [15:0]         tick_inc;
   logic                rebase;
   logic                grant_found;
   logic [GRANT_W-1:0]  grant_idx;
   logic [15:0]         stamp_sel;

   // take a command when the result register is free or being drained
   assign cmd_pop = cmd_valid && (!rsp_valid_ff || !rsp_stall);

   assign tick_inc  = tick_ff + 16'd1;
   assign rebase    = (tick_inc >= wrap_limit);
   assign stamp_sel = stamp_ff[cmd.handle[ADDR_W-1:0]];

   // lowest free timer
   always_comb begin
      grant_found = 1'b0;
      grant_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            grant_found = 1'b1;
            grant_idx   = GRANT_W'(i);
         end
      end
   end

   // execute one command
   always_comb begin
      tick_in = tick_ff;
      busy_in = busy_ff;
      for (int i = 0; i < ADDR_DEPTH; i++) begin
         stamp_in[i] = stamp_ff[i];
      end
      rsp_in.ok         = 1'b1;
      rsp_in.handle_out = 3'd0;
      rsp_in.elapsed    = 16'd0;
      if (cmd_pop) begin
         unique case (cmd.op)
            thp_pkg::OP_TICK: begin
               if (rebase) begin
                  tick_in = 16'd0;
                  for (int i = 0; i < ADDR_DEPTH; i++) begin
                     if (busy_ff[i]) begin
                        stamp_in[i] = stamp_ff[i] - tick_inc;
                     end
                  end
               end else begin
                  tick_in = tick_inc;
               end
            end
            thp_pkg::OP_ALLOC: begin
               rsp_in.ok = grant_found;
               if (grant_found) begin
                  busy_in[grant_idx] = 1'b1;
                  rsp_in.handle_out  = 3'(grant_idx);
               end
            end
            thp_pkg::OP_FREE: begin
               for (int i = 0; i < ADDR_DEPTH; i++) begin
                  if (cmd.handle_ok && cmd.handle == 3'(i)) begin
                     busy_in[i] = 1'b0;
                  end
               end
            end
            thp_pkg::OP_RESTART: begin
               for (int i = 0; i < ADDR_DEPTH; i++) begin
                  if (cmd.handle_ok && cmd.handle == 3'(i)) begin
                     stamp_in[i] = tick_ff;
                  end
               end
            end
            thp_pkg::OP_READ: begin
               if (cmd.handle_ok) begin
                  rsp_in.elapsed = tick_ff - stamp_sel;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result register handshake
   always_comb begin
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= 16'd0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ADDR_DEPTH; i++) begin
            stamp_ff[i] <= 16'd0;
         end
      end else begin
         tick_ff      <= tick_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ADDR_DEPTH; i++) begin
            stamp_ff[i] <= stamp_in[i];
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: rtl/core/thp_checker.sv
// port-level checks of the timer handle pool and their binding
module thp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_ok,
   input logic  [2:0] rsp_handle_out,
   input logic [15:0] rsp_elapsed,
   input logic        csr_psel,
   input logic        csr_pready
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok)
         && $stable(rsp_handle_out) && $stable(rsp_elapsed))
      else $error("response changed while stalled");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a failed allocate carries no handle and no elapsed count
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_handle_out == 3'd0 && rsp_elapsed == 16'd0)
      else $error("failed allocate with nonzero payload");

   // a granted handle and an elapsed count never appear together
   a_one_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_handle_out != 3'd0 |-> rsp_elapsed == 16'd0 && rsp_ok)
      else $error("granted handle mixed with elapsed count");

   // the csr port never waits
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("csr port not ready");

endmodule

bind timer_handle_pool_top thp_checker u_thp_checker (.*);

// File: test/timer_handle_pool_top_test.sv
// self-checking testbench of the timer handle pool: directed table, then random actions
module timer_handle_pool_top_test;

   localparam int POOL_SIZE   = 8;
   localparam int LONG_HOLD   = 40;
   localparam int PHASE_ITEMS = 140;
   localparam int NUM_PHASES  = 6;
   localparam int RUN_LIMIT   = 800000;

   // action codes the block decodes as no operation
   localparam logic [2:0] ACT_SPARE_A = 3'd5;
   localparam logic [2:0] ACT_SPARE_B = 3'd6;
   localparam logic [2:0] ACT_SPARE_C = 3'd7;

   // byte address of the wrap limit register
   localparam logic [2:0] WRAP_LIMIT_ADDR = {thp_pkg::REG_WRAP_LIMIT, 2'b00};

   // one row of the directed table: action, handle, typed-in flag, typed-in result
   typedef struct packed {
      logic [2:0]       act;
      logic [2:0]       hdl;
      logic             typed;
      thp_pkg::rsp_type want;
   } probe_row_type;

   localparam int PROBE_COUNT = 25;
   localparam probe_row_type PROBE_ROWS [PROBE_COUNT] = '{
      {thp_pkg::ACT_READ,    3'd0, 1'b1, 1'b1, 3'd0, 16'd0},
      {thp_pkg::ACT_TICK,    3'd5, 1'b1, 1'b1, 3'd0, 16'd0},
      {thp_pkg::ACT_READ,    3'd7, 1'b1, 1'b1, 3'd0, 16'd1},
      {thp_pkg::ACT_ALLOC,   3'd7, 1'b1, 1'b1, 3'd0, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd0, 1'b1, 1'b1, 3'd1, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd5, 1'b1, 1'b1, 3'd2, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd2, 1'b1, 1'b1, 3'd3, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd3, 1'b1, 1'b1, 3'd4, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd4, 1'b1, 1'b1, 3'd5, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd6, 1'b1, 1'b1, 3'd6, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd1, 1'b1, 1'b1, 3'd7, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd0, 1'b1, 1'b0, 3'd0, 16'd0},
      {thp_pkg::ACT_RESTART, 3'd3, 1'b1, 1'b1, 3'd0, 16'd0},
      {thp_pkg::ACT_TICK,    3'd0, 1'b1, 1'b1, 3'd0, 16'd0},
      {thp_pkg::ACT_TICK,    3'd7, 1'b1, 1'b1, 3'd0, 16'd0},
      {thp_pkg::ACT_READ,    3'd3, 1'b1, 1'b1, 3'd0, 16'd2},
      {thp_pkg::ACT_FREE,    3'd7, 1'b1, 1'b1, 3'd0, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd0, 1'b1, 1'b1, 3'd7, 16'd0},
      {ACT_SPARE_A,          3'd7, 1'b1, 1'b1, 3'd0, 16'd0},
      {ACT_SPARE_B,          3'd2, 1'b1, 1'b1, 3'd0, 16'd0},
      {ACT_SPARE_C,          3'd5, 1'b1, 1'b1, 3'd0, 16'd0},
      {thp_pkg::ACT_READ,    3'd0, 1'b1, 1'b1, 3'd0, 16'd3},
      {thp_pkg::ACT_FREE,    3'd0, 1'b0, 1'b0, 3'd0, 16'd0},
      {thp_pkg::ACT_READ,    3'd6, 1'b0, 1'b0, 3'd0, 16'd0},
      {thp_pkg::ACT_ALLOC,   3'd4, 1'b0, 1'b0, 3'd0, 16'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic  [2:0] req_action = 3'd0;
   logic  [2:0] req_handle = 3'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic  [2:0] rsp_handle_out;
   logic [15:0] rsp_elapsed;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic  [2:0] csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // mirror of the timer state
   logic [15:0] tick_now = 16'd0;
   logic [15:0] wrap_at = thp_pkg::WRAP_LIMIT_RESET;
   logic [15:0] stamp_of [POOL_SIZE];
   logic        busy_of [POOL_SIZE];

   thp_pkg::rsp_type pending_rsp_q [$];
   int      fault_count = 0;
   int      req_idle_pct = 21;
   int      rsp_idle_pct = 74;
   int      hold_asked = 0;

   timer_handle_pool_top #(
      .NUM_TIMERS(POOL_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_handle(req_handle),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ok(rsp_ok),
      .rsp_handle_out(rsp_handle_out),
      .rsp_elapsed(rsp_elapsed),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         stamp_of[i] = 16'd0;
         busy_of[i] = 1'b0;
      end
   end

   // count a failure, print only the first few
   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // apply one action to the mirror state and return the response it gives
   function automatic thp_pkg::rsp_type apply_action(input logic [2:0] act,
                                                     input logic [2:0] hdl);
      thp_pkg::rsp_type r;
      logic    found;
      int      i;
      r = {1'b1, 3'd0, 16'd0};
      found = 1'b0;
      case (act)
         thp_pkg::ACT_TICK: begin
            // counter wraps mod 2^16 before the compare, then rebase busy timers
            tick_now = tick_now + 16'd1;
            if (tick_now >= wrap_at) begin
               for (i = 0; i < POOL_SIZE; i++) begin
                  if (busy_of[i]) begin
                     stamp_of[i] = stamp_of[i] - tick_now;
                  end
               end
               tick_now = 16'd0;
            end
         end
         thp_pkg::ACT_ALLOC: begin
            // lowest free handle wins, stamp left as it is
            r.ok = 1'b0;
            for (i = 0; i < POOL_SIZE; i++) begin
               if (!found && !busy_of[i]) begin
                  found = 1'b1;
                  busy_of[i] = 1'b1;
                  r.ok = 1'b1;
                  r.handle_out = i[2:0];
               end
            end
         end
         thp_pkg::ACT_FREE: begin
            if (hdl < POOL_SIZE) begin
               busy_of[hdl] = 1'b0;
            end
         end
         thp_pkg::ACT_RESTART: begin
            if (hdl < POOL_SIZE) begin
               stamp_of[hdl] = tick_now;
            end
         end
         thp_pkg::ACT_READ: begin
            // a free timer still answers from its stamp
            if (hdl < POOL_SIZE) begin
               r.elapsed = tick_now - stamp_of[hdl];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // offer one action, after a random gap, and wait for its transfer
   task automatic drive_request(input logic [2:0] act, input logic [2:0] hdl,
                                input logic typed, input thp_pkg::rsp_type want);
      thp_pkg::rsp_type guess;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_handle <= hdl;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      guess = apply_action(act, hdl);
      pending_rsp_q.push_back(typed ? want : guess);
      @(negedge clock);
   endtask

   // write the wrap limit, then read it back
   task automatic write_wrap_limit(input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= WRAP_LIMIT_ADDR;
      csr_pwdata <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      wrap_at = value;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      if (csr_prdata !== {16'd0, value}) begin
         log_fault($sformatf("wrap limit readback: expected %0d, got %0d",
                             value, csr_prdata));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // response side stall, with a long hold-off on request
   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // compare each response transfer with the oldest expected one
   always @(posedge clock) begin
      thp_pkg::rsp_type got;
      thp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_ok, rsp_handle_out, rsp_elapsed};
         if (pending_rsp_q.size() == 0) begin
            log_fault($sformatf("unexpected response: ok %0d handle %0d elapsed %0d",
                                got.ok, got.handle_out, got.elapsed));
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.ok !== want.ok || got.handle_out !== want.handle_out ||
                got.elapsed !== want.elapsed) begin
               log_fault($sformatf({"response mismatch: expected ok %0d handle %0d ",
                                    "elapsed %0d, got ok %0d handle %0d elapsed %0d"},
                                   want.ok, want.handle_out, want.elapsed,
                                   got.ok, got.handle_out, got.elapsed));
            end
         end
      end
   end

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus: directed table, then one random phase per wrap limit setting
   initial begin : stimulus
      logic [15:0] wrap_plan [NUM_PHASES];
      logic  [2:0] act;
      logic  [2:0] hdl;
      int          pick;
      wrap_plan[0] = 16'd0;
      wrap_plan[1] = 16'd1;
      wrap_plan[2] = 16'hFFFF;
      wrap_plan[3] = 16'd5;
      wrap_plan[4] = 16'd12;
      wrap_plan[5] = 16'($urandom_range(40, 2));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table at the reset wrap limit
      for (int r = 0; r < PROBE_COUNT; r++) begin
         drive_request(PROBE_ROWS[r].act, PROBE_ROWS[r].hdl,
                       PROBE_ROWS[r].typed, PROBE_ROWS[r].want);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // idle pattern: sender light first, then receiver light, then none
         if (phase == 2) begin
            req_idle_pct = 74;
            rsp_idle_pct = 21;
         end else if (phase == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         // drain before touching the register
         req_valid <= 1'b0;
         do begin
            @(negedge clock);
         end while (pending_rsp_q.size() != 0);
         repeat (4) @(negedge clock);
         write_wrap_limit(wrap_plan[phase]);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while requests keep coming
            if ((phase == 1 || phase == 4) && n == 30) begin
               hold_asked++;
            end
            // sender pause until every response is back
            if (phase == 3 && n == 70) begin
               req_valid <= 1'b0;
               do begin
                  @(negedge clock);
               end while (pending_rsp_q.size() != 0);
            end

            // weighted action mix, ticks most common
            pick = $urandom_range(99);
            if (pick < 5) begin
               act = 3'($urandom_range(ACT_SPARE_C, ACT_SPARE_A));
            end else if (pick < 40) begin
               act = thp_pkg::ACT_TICK;
            end else if (pick < 55) begin
               act = thp_pkg::ACT_ALLOC;
            end else if (pick < 70) begin
               act = thp_pkg::ACT_FREE;
            end else if (pick < 85) begin
               act = thp_pkg::ACT_RESTART;
            end else begin
               act = thp_pkg::ACT_READ;
            end
            hdl = 3'($urandom_range(7));
            drive_request(act, hdl, 1'b0, '0);
         end
      end

      // wait for the last responses, then watch for strays
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending_rsp_q.size() != 0);
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
